@@ hw/rtl/mbts_pkg.sv @@
// Package: shared constants and codes for the mipmap build and trilinear sample unit.
`default_nettype none
package mbts_pkg;

   // default pyramid size limit (log2 of the largest base dimension)
   localparam int MAX_LOG2_SIZE_DEF = 8;

   // fixed field widths
   localparam int TEXEL_BITS      = 16;
   localparam int COORD_BITS      = 20;
   localparam int COORD_FRAC_BITS = 16;
   localparam int WIDTH_BITS      = 24;
   localparam int LOD_FRAC_BITS   = 8;
   localparam int LG_BITS         = 4;

   // item kinds
   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_BUILD  = 2'd1;
   localparam logic [1:0] KIND_LOOKUP = 2'd2;

   // result kinds
   localparam logic RES_SAMPLE = 1'b0;
   localparam logic RES_BUILD  = 1'b1;

   // wrap modes
   localparam logic [1:0] WRAP_REPEAT = 2'd0;
   localparam logic [1:0] WRAP_CLAMP  = 2'd1;
   localparam logic [1:0] WRAP_BLACK  = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_WRAP_MODE = 2'd0;
   localparam logic [1:0] CSR_LOG2_W    = 2'd1;
   localparam logic [1:0] CSR_LOG2_H    = 2'd2;

endpackage
`default_nettype wire

@@ hw/rtl/mbts_fetch.sv @@
// Texel address unit: applies the wrap rule and forms the store address of one texel.
`default_nettype none
module mbts_fetch #(
   parameter int MAX_LOG2_SIZE = mbts_pkg::MAX_LOG2_SIZE_DEF,
   localparam int AW = 2 * MAX_LOG2_SIZE + 1,
   localparam int SW = MAX_LOG2_SIZE + 6
) (
   input  wire logic [AW-1:0]                  base,
   input  wire logic [mbts_pkg::LG_BITS-1:0]   lgw,
   input  wire logic [mbts_pkg::LG_BITS-1:0]   lgh,
   input  wire logic signed [SW-1:0]           s,
   input  wire logic signed [SW-1:0]           t,
   input  wire logic [1:0]                     wrap,
   output logic [AW-1:0]                       addr,
   output logic                                zero
);
   localparam int M = MAX_LOG2_SIZE;

   logic [SW-1:0] one_s;
   logic [SW-1:0] mask_w;
   logic [SW-1:0] mask_h;
   logic          s_lo, s_hi, t_lo, t_hi;
   logic [SW-1:0] s_w;
   logic [SW-1:0] t_w;

   assign one_s  = SW'(1);
   assign mask_w = (one_s << lgw) - one_s;
   assign mask_h = (one_s << lgh) - one_s;
   assign s_lo   = s[SW-1];
   assign t_lo   = t[SW-1];
   assign s_hi   = !s[SW-1] && (SW'(s) > mask_w);
   assign t_hi   = !t[SW-1] && (SW'(t) > mask_h);

   // wrap rule; code three behaves as clamp
   always_comb begin
      zero = 1'b0;
      unique case (wrap)
         mbts_pkg::WRAP_REPEAT: begin
            s_w = SW'(s) & mask_w;
            t_w = SW'(t) & mask_h;
         end
         mbts_pkg::WRAP_BLACK: begin
            s_w  = SW'(s);
            t_w  = SW'(t);
            zero = s_lo || s_hi || t_lo || t_hi;
         end
         default: begin
            s_w = s_lo ? '0 : (s_hi ? mask_w : SW'(s));
            t_w = t_lo ? '0 : (t_hi ? mask_h : SW'(t));
         end
      endcase
   end

   // row-major within the level
   assign addr = base + (AW'(t_w[M-1:0]) << lgw) + AW'(s_w[M-1:0]);

endmodule
`default_nettype wire

@@ hw/rtl/mipmap_build_and_trilinear_sample_unit.sv @@
// Top level: texel store, pyramid build sequencer and trilinear lookup sequencer.
// Write: no result. Build: the fetches for every coarser texel all go
//   through the single store read port.
// Lookup: 8 log2 squarings, two bilinear passes of 4 fetches and
//   6 multiplies, and 2 blend multiplies; the squarings and multiplies share one
//   32x32 multiplier; a single fetch replaces the passes when the footprint lies above the top level.
// One item at a time; a finished result waits in the output register.
// Synchronous reset clears control and configuration registers; datapath registers and the texel store are not cleared.
`default_nettype none
module mipmap_build_and_trilinear_sample_unit #(
   parameter int MAX_LOG2_SIZE = mbts_pkg::MAX_LOG2_SIZE_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_kind,
   input  wire logic [7:0]                           req_write_col,
   input  wire logic [7:0]                           req_write_row,
   input  wire logic [mbts_pkg::TEXEL_BITS-1:0]      req_texel_value,
   input  wire logic signed [mbts_pkg::COORD_BITS-1:0] req_coord_s,
   input  wire logic signed [mbts_pkg::COORD_BITS-1:0] req_coord_t,
   input  wire logic [mbts_pkg::WIDTH_BITS-1:0]      req_filter_width,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_result_kind,
   output logic [mbts_pkg::TEXEL_BITS-1:0]           rsp_sample_value,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [1:0]                           csr_index,
   input  wire logic [mbts_pkg::LG_BITS-1:0]         csr_wdata
);
   localparam int M     = MAX_LOG2_SIZE;
   localparam int AW    = 2 * M + 1;
   localparam int DEPTH = ((1 << (2 * (M + 1))) - 1) / 3;
   localparam int SW    = M + 6;
   localparam int CB    = mbts_pkg::COORD_BITS;
   localparam int UW    = CB + M + 1;
   localparam int FB    = mbts_pkg::COORD_FRAC_BITS;
   localparam int TB    = mbts_pkg::TEXEL_BITS;
   localparam int LB    = mbts_pkg::LG_BITS;
   localparam int WIDTH_BITS_L = mbts_pkg::WIDTH_BITS;
   localparam logic [LB-1:0] M_LG = LB'(M);
   localparam logic [UW-1:0] HALF_U = UW'(1) << (FB - 1);
   localparam logic [16:0]   ONE_F  = 17'h10000;

   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_BSET    = 4'd1;
   localparam logic [3:0] S_BFETCH  = 4'd2;
   localparam logic [3:0] S_BWRITE  = 4'd3;
   localparam logic [3:0] S_LOGMUL  = 4'd4;
   localparam logic [3:0] S_LOGNORM = 4'd5;
   localparam logic [3:0] S_LEV     = 4'd6;
   localparam logic [3:0] S_LSET    = 4'd7;
   localparam logic [3:0] S_LFETCH  = 4'd8;
   localparam logic [3:0] S_LMUL    = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;

   // offset of a level: sum of the sizes of all finer levels
   function automatic logic [AW-1:0] lvl_base(input logic [LB-1:0] lw,
                                              input logic [LB-1:0] lh,
                                              input logic [LB-1:0] lvl);
      logic [AW-1:0] acc;
      logic [LB-1:0] dw, dh;
      acc = '0;
      for (int j = 0; j < M; j++) begin
         dw = (lw > LB'(j)) ? lw - LB'(j) : '0;
         dh = (lh > LB'(j)) ? lh - LB'(j) : '0;
         if (LB'(j) < lvl) acc = acc + (AW'(1) << ((LB + 1)'(dw) + (LB + 1)'(dh)));
      end
      return acc;
   endfunction

   // log2 dimension of a level
   function automatic logic [LB-1:0] lvl_lg(input logic [LB-1:0] lg,
                                            input logic [LB-1:0] lvl);
      return (lg > lvl) ? lg - lvl : '0;
   endfunction

   // control and configuration registers
   logic [3:0]    state_ff, state_in;
   logic [1:0]    wrap_ff;
   logic [LB-1:0] lwreg_ff, lhreg_ff;
   logic [LB-1:0] lc_ff, lc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic [TB-1:0] rsp_val_ff, rsp_val_in;

   // datapath registers
   logic signed [CB-1:0] cs_ff, cs_in, ct_ff, ct_in;
   logic [31:0]   m_ff, m_in;
   logic [4:0]    p_ff, p_in;
   logic [7:0]    frac_ff, frac_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic [LB-1:0] lvl_ff, lvl_in, lv1_ff, lv1_in;
   logic          pass_ff, pass_in, top_ff, top_in;
   logic [7:0]    f_ff, f_in;
   logic [AW-1:0] base_ff, base_in, dbase_ff, dbase_in;
   logic [LB-1:0] lgw_ff, lgw_in, lgh_ff, lgh_in, dlgw_ff, dlgw_in, dlgh_ff, dlgh_in;
   logic [M-1:0]  s_ff, s_in, t_ff, t_in;
   logic signed [SW-1:0] is_ff, is_in, it_ff, it_in;
   logic [FB-1:0] ds_ff, ds_in, dt_ff, dt_in;
   logic [TB-1:0] tex_ff [4];
   logic [TB-1:0] tex_in [4];
   logic [TB-1:0] r0_ff, r0_in, r1_ff, r1_in, v0_ff, v0_in, v1_ff, v1_in;
   logic [TB-1:0] res_val_ff, res_val_in;
   logic          res_kind_ff, res_kind_in;
   logic [2:0]    k_ff, k_in;
   logic          ph_ff, ph_in;
   logic [33:0]   acc_ff, acc_in;
   logic [63:0]   prod_ff;
   logic [TB-1:0] rd_ff;
   logic          zero_d_ff;

   // store and its ports
   logic [TB-1:0] mem [DEPTH];
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [TB-1:0] mem_wdata;
   logic [AW-1:0] rd_addr;
   logic          rd_zero;

   // shared multiplier
   logic [31:0]   mul_a, mul_b;

   // fetch unit inputs
   logic signed [SW-1:0] f_s, f_t;

   logic          req_xfer;
   logic [LB-1:0] lw_sat, lh_sat;
   logic [WIDTH_BITS_L-1:0] x_w;
   logic [4:0]    p_c;
   logic [32:0]   q_c;
   logic [15:0]   top16, lev16;
   logic          lev_gt;
   logic [LB-1:0] lgw_c, lgh_c;
   logic [UW-1:0] us_c, ut_c;
   logic [17:0]   sum4;
   logic [M:0]    wmask, hmask;
   logic [33:0]   pair_sum;
   logic [LB-1:0] lc_new;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_sample_value = rsp_val_ff;

   assign lw_sat = (lwreg_ff > M_LG) ? M_LG : lwreg_ff;
   assign lh_sat = (lhreg_ff > M_LG) ? M_LG : lhreg_ff;
   assign lc_new = LB'(1) + ((lw_sat > lh_sat) ? lw_sat : lh_sat);

   // leading one of the filter width
   assign x_w = (req_filter_width == '0) ? WIDTH_BITS_L'(1) : req_filter_width;
   always_comb begin
      p_c = '0;
      for (int i = 0; i < WIDTH_BITS_L; i++) begin
         if (x_w[i]) p_c = 5'(i);
      end
   end

   // level of detail in 8.8 fixed point
   assign q_c    = prod_ff[63:31];
   assign top16  = {4'd0, lc_ff - LB'(1), 8'd0};
   assign lev16  = top16 + {3'd0, p_ff, frac_ff} - 16'd4096;
   assign lev_gt = !lev16[15] && (lev16 > top16);

   // coordinate split for the current level
   assign lgw_c = lvl_lg(lw_sat, lvl_ff);
   assign lgh_c = lvl_lg(lh_sat, lvl_ff);
   assign us_c  = (UW'(cs_ff) << lgw_c) - HALF_U;
   assign ut_c  = (UW'(ct_ff) << lgh_c) - HALF_U;

   assign sum4  = 18'(tex_ff[0]) + 18'(tex_ff[1]) + 18'(tex_ff[2]) + 18'(tex_ff[3]) + 18'd2;
   assign wmask = ((M + 1)'(1) << dlgw_ff) - (M + 1)'(1);
   assign hmask = ((M + 1)'(1) << dlgh_ff) - (M + 1)'(1);
   assign pair_sum = acc_ff + prod_ff[33:0];

   // fetch coordinates: 2x2 block in a build, bilinear footprint in a lookup
   always_comb begin
      if (state_ff == S_BFETCH) begin
         f_s = SW'({s_ff, cnt_ff[0]});
         f_t = SW'({t_ff, cnt_ff[1]});
      end else if (top_ff) begin
         f_s = '0;
         f_t = '0;
      end else begin
         f_s = is_ff + SW'(cnt_ff[0]);
         f_t = it_ff + SW'(cnt_ff[1]);
      end
   end

   mbts_fetch #(.MAX_LOG2_SIZE(MAX_LOG2_SIZE)) u_fetch (
      .base (base_ff),
      .lgw  (lgw_ff),
      .lgh  (lgh_ff),
      .s    (f_s),
      .t    (f_t),
      .wrap (wrap_ff),
      .addr (rd_addr),
      .zero (rd_zero)
   );

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_LOGMUL) begin
         mul_a = m_ff;
         mul_b = m_ff;
      end else begin
         unique case (k_ff)
            3'd0: begin mul_a = 32'(tex_ff[0]); mul_b = 32'(ONE_F - 17'(ds_ff)); end
            3'd1: begin mul_a = 32'(tex_ff[1]); mul_b = 32'(ds_ff); end
            3'd2: begin mul_a = 32'(tex_ff[2]); mul_b = 32'(ONE_F - 17'(ds_ff)); end
            3'd3: begin mul_a = 32'(tex_ff[3]); mul_b = 32'(ds_ff); end
            3'd4: begin mul_a = 32'(r0_ff); mul_b = 32'(ONE_F - 17'(dt_ff)); end
            3'd5: begin mul_a = 32'(r1_ff); mul_b = 32'(dt_ff); end
            3'd6: begin mul_a = 32'(v0_ff); mul_b = 32'(9'd256 - 9'(f_ff)); end
            default: begin mul_a = 32'(v1_ff); mul_b = 32'(f_ff); end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      lc_in       = lc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in = rsp_kind_ff;
      rsp_val_in  = rsp_val_ff;
      cs_in = cs_ff;  ct_in = ct_ff;
      m_in = m_ff;  p_in = p_ff;  frac_in = frac_ff;
      cnt_in = cnt_ff;
      lvl_in = lvl_ff;  lv1_in = lv1_ff;
      pass_in = pass_ff;  top_in = top_ff;  f_in = f_ff;
      base_in = base_ff;  dbase_in = dbase_ff;
      lgw_in = lgw_ff;  lgh_in = lgh_ff;  dlgw_in = dlgw_ff;  dlgh_in = dlgh_ff;
      s_in = s_ff;  t_in = t_ff;
      is_in = is_ff;  it_in = it_ff;  ds_in = ds_ff;  dt_in = dt_ff;
      tex_in = tex_ff;
      r0_in = r0_ff;  r1_in = r1_ff;  v0_in = v0_ff;  v1_in = v1_ff;
      res_val_in = res_val_ff;  res_kind_in = res_kind_ff;
      k_in = k_ff;  ph_in = ph_ff;  acc_in = acc_ff;
      mem_we    = 1'b0;
      mem_waddr = (AW'(req_write_row) << lw_sat) + AW'(req_write_col);
      mem_wdata = req_texel_value;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               unique case (req_kind)
                  mbts_pkg::KIND_WRITE: begin
                     mem_we = ((16'(req_write_col) >> lw_sat) == '0) &&
                              ((16'(req_write_row) >> lh_sat) == '0);
                  end
                  mbts_pkg::KIND_BUILD: begin
                     lc_in       = lc_new;
                     res_kind_in = mbts_pkg::RES_BUILD;
                     res_val_in  = '0;
                     lvl_in      = LB'(1);
                     state_in    = (lc_new == LB'(1)) ? S_DONE : S_BSET;
                  end
                  mbts_pkg::KIND_LOOKUP: begin
                     cs_in    = req_coord_s;
                     ct_in    = req_coord_t;
                     p_in     = p_c;
                     m_in     = 32'(x_w) << (5'd31 - p_c);
                     frac_in  = '0;
                     cnt_in   = '0;
                     state_in = S_LOGMUL;
                  end
                  default: ;
               endcase
            end
         end

         // per level: source and destination geometry
         S_BSET: begin
            base_in  = lvl_base(lw_sat, lh_sat, lvl_ff - LB'(1));
            dbase_in = lvl_base(lw_sat, lh_sat, lvl_ff);
            lgw_in   = lvl_lg(lw_sat, lvl_ff - LB'(1));
            lgh_in   = lvl_lg(lh_sat, lvl_ff - LB'(1));
            dlgw_in  = lgw_c;
            dlgh_in  = lgh_c;
            s_in     = '0;
            t_in     = '0;
            cnt_in   = '0;
            top_in   = 1'b0;
            state_in = S_BFETCH;
         end

         S_BFETCH, S_LFETCH: begin
            if (cnt_ff != 3'd0) tex_in[2'(cnt_ff - 3'd1)] = zero_d_ff ? '0 : rd_ff;
            cnt_in = cnt_ff + 3'd1;
            if (state_ff == S_BFETCH) begin
               if (cnt_ff == 3'd4) state_in = S_BWRITE;
            end else if (top_ff) begin
               if (cnt_ff == 3'd1) begin
                  res_val_in = zero_d_ff ? '0 : rd_ff;
                  state_in   = S_DONE;
               end
            end else if (cnt_ff == 3'd4) begin
               k_in     = '0;
               ph_in    = 1'b0;
               state_in = S_LMUL;
            end
         end

         // write one averaged texel, then step through the level
         S_BWRITE: begin
            mem_we    = 1'b1;
            mem_waddr = dbase_ff + (AW'(t_ff) << dlgw_ff) + AW'(s_ff);
            mem_wdata = sum4[17:2];
            cnt_in    = '0;
            state_in  = S_BFETCH;
            if ((M + 1)'(s_ff) == wmask) begin
               s_in = '0;
               t_in = t_ff + M'(1);
               if ((M + 1)'(t_ff) == hmask) begin
                  if (lvl_ff == lc_ff - LB'(1)) begin
                     state_in = S_DONE;
                  end else begin
                     lvl_in   = lvl_ff + LB'(1);
                     state_in = S_BSET;
                  end
               end
            end else begin
               s_in = s_ff + M'(1);
            end
         end

         S_LOGMUL: state_in = S_LOGNORM;

         // one fraction bit of log2 per squaring
         S_LOGNORM: begin
            if (q_c[32]) begin
               m_in    = q_c[32:1];
               frac_in = {frac_ff[6:0], 1'b1};
            end else begin
               m_in    = q_c[31:0];
               frac_in = {frac_ff[6:0], 1'b0};
            end
            cnt_in   = cnt_ff + 3'd1;
            state_in = (cnt_ff == 3'd7) ? S_LEV : S_LOGMUL;
         end

         // pick the two levels and the blend weight
         S_LEV: begin
            pass_in     = 1'b0;
            res_kind_in = mbts_pkg::RES_SAMPLE;
            top_in      = lev_gt;
            state_in    = S_LSET;
            if (lev_gt) begin
               lvl_in = lc_ff - LB'(1);
               f_in   = '0;
               lv1_in = lc_ff - LB'(1);
            end else if (lev16[15]) begin
               lvl_in = '0;
               f_in   = '0;
               lv1_in = (lc_ff > LB'(1)) ? LB'(1) : '0;
            end else begin
               lvl_in = lev16[11:8];
               f_in   = lev16[7:0];
               lv1_in = (lev16[11:8] >= lc_ff - LB'(1)) ? lc_ff - LB'(1)
                                                        : lev16[11:8] + LB'(1);
            end
         end

         S_LSET: begin
            base_in  = lvl_base(lw_sat, lh_sat, lvl_ff);
            lgw_in   = lgw_c;
            lgh_in   = lgh_c;
            is_in    = {us_c[UW-1], us_c[UW-1:FB]};
            it_in    = {ut_c[UW-1], ut_c[UW-1:FB]};
            ds_in    = us_c[FB-1:0];
            dt_in    = ut_c[FB-1:0];
            cnt_in   = '0;
            state_in = S_LFETCH;
         end

         // multiply, then accumulate or round, on the shared multiplier
         S_LMUL: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               if (!k_ff[0]) begin
                  acc_in = prod_ff[33:0] + ((k_ff == 3'd6) ? 34'd128 : 34'd32768);
                  k_in   = k_ff + 3'd1;
               end else begin
                  unique case (k_ff)
                     3'd1: begin r0_in = pair_sum[31:16]; k_in = 3'd2; end
                     3'd3: begin r1_in = pair_sum[31:16]; k_in = 3'd4; end
                     3'd5: begin
                        if (!pass_ff) begin
                           v0_in    = pair_sum[31:16];
                           pass_in  = 1'b1;
                           lvl_in   = lv1_ff;
                           state_in = S_LSET;
                        end else begin
                           v1_in = pair_sum[31:16];
                           k_in  = 3'd6;
                        end
                     end
                     default: begin
                        res_val_in = pair_sum[23:8];
                        state_in   = S_DONE;
                     end
                  endcase
               end
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_val_in   = res_val_ff;
               top_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wrap_ff      <= mbts_pkg::WRAP_CLAMP;
         lwreg_ff     <= LB'(8);
         lhreg_ff     <= LB'(8);
         lc_ff        <= LB'(1);
         rsp_valid_ff <= 1'b0;
         top_ff       <= 1'b0;
         pass_ff      <= 1'b0;
         cnt_ff       <= '0;
         k_ff         <= '0;
         ph_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lc_ff        <= lc_in;
         rsp_valid_ff <= rsp_valid_in;
         top_ff       <= top_in;
         pass_ff      <= pass_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         ph_ff        <= ph_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               mbts_pkg::CSR_WRAP_MODE: wrap_ff  <= csr_wdata[1:0];
               mbts_pkg::CSR_LOG2_W:    lwreg_ff <= csr_wdata;
               mbts_pkg::CSR_LOG2_H:    lhreg_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_val_ff  <= rsp_val_in;
      cs_ff <= cs_in;  ct_ff <= ct_in;
      m_ff <= m_in;  p_ff <= p_in;  frac_ff <= frac_in;
      lvl_ff <= lvl_in;  lv1_ff <= lv1_in;  f_ff <= f_in;
      base_ff <= base_in;  dbase_ff <= dbase_in;
      lgw_ff <= lgw_in;  lgh_ff <= lgh_in;  dlgw_ff <= dlgw_in;  dlgh_ff <= dlgh_in;
      s_ff <= s_in;  t_ff <= t_in;
      is_ff <= is_in;  it_ff <= it_in;  ds_ff <= ds_in;  dt_ff <= dt_in;
      tex_ff <= tex_in;
      r0_ff <= r0_in;  r1_ff <= r1_in;  v0_ff <= v0_in;  v1_ff <= v1_in;
      res_val_ff <= res_val_in;  res_kind_ff <= res_kind_in;
      acc_ff  <= acc_in;
      prod_ff <= mul_a * mul_b;
   end

   // texel store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_ff     <= mem[rd_addr];
      zero_d_ff <= rd_zero;
   end

   // a new result only comes out of the completion state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside completion");

   // the store is written only by a base write or a build step
   a_write_src: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_IDLE || state_ff == S_BWRITE))
      else $error("store write from wrong state");

   // level count stays within the pyramid
   a_lc_range: assert property (@(posedge clock) disable iff (reset)
      (lc_ff != '0) && (lc_ff <= LB'(M + 1)))
      else $error("level count out of range");

   // a waiting result holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid_ff && rsp_stall) |-> rsp_valid_ff && $stable(rsp_val_ff))
      else $error("stalled result changed");

endmodule
`default_nettype wire
